### src/dvru_pkg.sv
// ============================================================================
// dvru_pkg
// Shared types and constants for the distance-vector route update unit.
// ============================================================================
package dvru_pkg;

  // Defaults for the top-level parameters.
  localparam int DVRU_MAX_NODES = 16;
  localparam int DVRU_COST_BITS = 16;

  // Fixed field widths of the transaction payloads.
  localparam int NODE_W     = 4;
  localparam int COST_IN_W  = 16;
  localparam int COST_OUT_W = 17;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELF_INDEX = 4'd0,
    CFG_NODE_COUNT = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [NODE_W-1:0]    neighbor_id;
    logic [COST_IN_W-1:0] link_delay;
    logic [NODE_W-1:0]    dest_index;
    logic [COST_IN_W-1:0] advertised_cost;
    logic                 last_entry;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]     route_dest;
    logic [COST_OUT_W-1:0] path_cost;
    logic [NODE_W-1:0]     next_hop;
    logic                  is_self;
    logic                  unreachable;
    logic                  last_row;
  } out_item_t;

  // Classified entry handed from the front end to the update engine.
  typedef struct packed {
    logic [NODE_W-1:0]     hop;
    logic [NODE_W-1:0]     dest;
    logic [COST_OUT_W-1:0] cand;
    logic                  in_range;
    logic                  last_entry;
  } q_item_t;

  // Live configuration seen by the update engine.
  typedef struct packed {
    logic [NODE_W-1:0]  self_index;
    logic [COUNT_W-1:0] node_count;
  } cfg_t;

endpackage

### src/distance_vector_route_update_unit.sv
// ============================================================================
// distance_vector_route_update_unit
// Distance-vector (Bellman-Ford) route update with table emission.
// ============================================================================
// Neighbor entries arrive one per input transaction. Each entry's candidate
// cost (link delay plus advertised cost) is relaxed against the stored best
// for its destination; ties keep the earlier neighbor. An input stage forms
// the candidate and feeds a two-entry queue, so the input side keeps taking
// transactions while the update engine works. The engine takes one entry at
// a time: it reads the route memory, compares and writes back, and only then
// takes the next entry. An entry flagged last is applied first; then the
// engine walks destinations 0 .. node_count-1, a count of zero taken as one
// and a count above the table size capped to it, and emits one row per
// destination through an output register (memory read, then output load).
// The self row reports cost 0 and no next hop; destinations with no report
// come out as unreachable. After the final row all seen marks are cleared
// and a new table starts. No clearing pass is needed after reset.
// Configuration writes are accepted every cycle.
// ============================================================================
module distance_vector_route_update_unit
  import dvru_pkg::*;
#(
  parameter int MAX_NODES = DVRU_MAX_NODES,
  parameter int COST_BITS = DVRU_COST_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers are read live when a table is emitted.
  cfg_t    cfg_r;

  logic    push_valid;
  logic    push_ready;
  q_item_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  q_item_t pop_data;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_index <= '0;
      cfg_r.node_count <= COUNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SELF_INDEX: cfg_r.self_index <= cfg_data[NODE_W-1:0];
        CFG_NODE_COUNT: cfg_r.node_count <= cfg_data[COUNT_W-1:0];
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  dvru_front #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dvru_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dvru_back #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### src/dvru_front.sv
// ============================================================================
// dvru_front
// Input stage: registers each entry, forms the candidate cost and flags
// destinations outside the table.
// ============================================================================
module dvru_front
  import dvru_pkg::*;
#(
  parameter int MAX_NODES = DVRU_MAX_NODES,
  parameter int COST_BITS = DVRU_COST_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output q_item_t  push_data
);

  localparam int CW = (COST_BITS < COST_IN_W) ? COST_BITS : COST_IN_W;
  localparam logic [COST_IN_W-1:0] InMask = COST_IN_W'((33'h1 << CW) - 33'h1);

  logic    fr_valid_r;
  q_item_t fr_item_r;
  q_item_t item_nxt;
  logic    accept;

  always_comb begin
    item_nxt.hop        = in_data.neighbor_id;
    item_nxt.dest       = in_data.dest_index;
    item_nxt.cand       = {1'b0, in_data.link_delay & InMask}
                        + {1'b0, in_data.advertised_cost & InMask};
    item_nxt.in_range   = (32'(in_data.dest_index) < MAX_NODES);
    item_nxt.last_entry = in_data.last_entry;
  end

  assign in_ready   = !fr_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = fr_valid_r;
  assign push_data  = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fr_valid_r <= 1'b1;
        fr_item_r  <= item_nxt;
      end else if (push_ready) begin
        fr_valid_r <= 1'b0;
      end
    end
  end

endmodule

### src/dvru_queue.sv
// ============================================================================
// dvru_queue
// Two-entry queue between the input stage and the update engine.
// ============================================================================
module dvru_queue
  import dvru_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_data
);

  q_item_t    slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### src/dvru_back.sv
// ============================================================================
// dvru_back
// Update engine: relaxes one entry against the route memory, and on the last
// entry walks the destinations to emit the routing table.
// ============================================================================
module dvru_back
  import dvru_pkg::*;
#(
  parameter int MAX_NODES = DVRU_MAX_NODES,
  parameter int COST_BITS = DVRU_COST_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  q_item_t   pop_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW     = $clog2(MAX_NODES);
  localparam int CW     = (COST_BITS < COST_IN_W) ? COST_BITS : COST_IN_W;
  localparam int SW     = CW + 1;
  localparam int RowMax = (MAX_NODES < 31) ? MAX_NODES : 31;
  localparam int RW     = (AW < COUNT_W) ? AW : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_ERD,
    S_EOUT
  } state_t;

  state_t                 state_r;
  q_item_t                cur_r;
  logic [RW-1:0]          row_r;
  logic [MAX_NODES-1:0]   seen_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [SW+NODE_W-1:0]   route_mem_r [MAX_NODES];
  logic [SW+NODE_W-1:0]   rd_data_r;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          cur_addr;
  logic [SW-1:0]          rd_cost;
  logic [NODE_W-1:0]      rd_hop;
  logic                   mem_we;
  logic                   upd_take;
  logic                   out_load;
  logic [COUNT_W-1:0]     n_eff;
  logic [RW-1:0]          last_idx;
  logic                   row_last;
  logic                   row_self;
  logic                   row_seen;
  out_item_t              row_item;

  assign cur_addr = AW'(cur_r.dest);
  assign rd_addr  = (state_r == S_IDLE) ? AW'(pop_data.dest) : AW'(row_r);
  assign rd_cost  = rd_data_r[SW+NODE_W-1:NODE_W];
  assign rd_hop   = rd_data_r[NODE_W-1:0];

  // For an in-range destination, a new best is taken on the first report or a strictly smaller cost.
  assign upd_take = cur_r.in_range
                  && (!seen_r[cur_addr] || (cur_r.cand[SW-1:0] < rd_cost));
  assign mem_we   = (state_r == S_UPD) && upd_take;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      route_mem_r[cur_addr] <= {cur_r.cand[SW-1:0], cur_r.hop};
    end
    rd_data_r <= route_mem_r[rd_addr];
  end

  always_comb begin
    if (cfg.node_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (32'(cfg.node_count) > RowMax) begin
      n_eff = COUNT_W'(RowMax);
    end else begin
      n_eff = cfg.node_count;
    end
  end

  assign last_idx = RW'(n_eff - COUNT_W'(1));
  assign row_last = (row_r == last_idx);
  assign row_self = ({1'b0, cfg.self_index} == COUNT_W'(row_r));
  assign row_seen = seen_r[AW'(row_r)];

  always_comb begin
    row_item.route_dest  = NODE_W'(row_r);
    row_item.path_cost   = (!row_self && row_seen) ? COST_OUT_W'(rd_cost) : '0;
    row_item.next_hop    = (!row_self && row_seen) ? rd_hop : '0;
    row_item.is_self     = row_self;
    row_item.unreachable = !row_self && !row_seen;
    row_item.last_row    = row_last;
  end

  assign out_load  = (state_r == S_EOUT) && (!out_valid_r || out_ready);
  assign pop_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            cur_r   <= pop_data;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_take) begin
            seen_r[cur_addr] <= 1'b1;
          end
          if (cur_r.last_entry) begin
            row_r   <= '0;
            state_r <= S_ERD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_ERD: begin
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (out_load) begin
            if (row_last) begin
              seen_r  <= '0;
              state_r <= S_IDLE;
            end else begin
              row_r   <= RW'(row_r + RW'(1));
              state_r <= S_ERD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= row_item;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> (state_r == S_IDLE))
    else $error("entry popped while engine busy");

  a_write_only_upd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_UPD))
    else $error("route memory written outside update");

  a_row_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EOUT) |-> (row_r <= last_idx))
    else $error("emission row beyond table size");

  a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && row_last) |=> (seen_r == '0))
    else $error("seen marks not cleared after table");

  a_last_row_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_data_r.last_row == $past(row_last)))
    else $error("last row flag mismatch");
`endif

endmodule

### sim/distance_vector_route_update_unit_tb.sv
// ============================================================================
// distance_vector_route_update_unit_tb
// Self-checking testbench for the distance-vector route update unit.
// ============================================================================
// A driver feeds neighbor entries from a backlog queue and a monitor takes
// the emitted route rows. Both sides idle at random. Every accepted entry is
// relaxed into a local copy of the route tables. Every entry flagged last
// produces the expected rows, which are then compared field by field with
// what the block emits. The run starts with a short directed part and then
// goes on with random batches of entries under changing register settings.
// ============================================================================
module distance_vector_route_update_unit_tb;
  import dvru_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 360;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT   = 3000000;

  // All block inputs start at known values before the first clock edge.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  distance_vector_route_update_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Entries waiting to be offered, and rows the block still owes us.
  in_item_t  entry_backlog[$];
  out_item_t rows_due[$];

  // Local copy of the route tables and of the two registers.
  logic [COST_OUT_W-1:0] route_cost [DVRU_MAX_NODES];
  logic [NODE_W-1:0]     route_hop  [DVRU_MAX_NODES];
  logic [DVRU_MAX_NODES-1:0] route_seen = '0;
  logic [NODE_W-1:0]     self_id    = '0;
  logic [COUNT_W-1:0]    dest_count = COUNT_W'(DVRU_MAX_NODES);

  // Generator-side view of the best sum offered per destination, used to
  // build exact ties against the currently stored best.
  int unsigned offer_best [DVRU_MAX_NODES];
  bit          offer_seen [DVRU_MAX_NODES];

  // Run control shared between the sequencer and the two handshake processes.
  bit          quiet       = 1'b0;  // no idling on either side
  bit          rx_hold_req = 1'b0;  // toggled to ask for one long receiver hold
  bit          rx_hold_ack = 1'b0;
  int unsigned tx_wait     = 0;
  int unsigned rx_wait     = 0;

  int unsigned n_pushed  = 0;
  int unsigned n_entries = 0;
  int unsigned n_rows    = 0;
  int unsigned n_tables  = 0;
  int unsigned n_cfg     = 0;
  int unsigned errors    = 0;
  int unsigned cycle_count = 0;

  // Mostly back-to-back, sometimes a few cycles, now and then a long gap.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(8, 4);
    return $urandom_range(40, 20);
  endfunction

  // A node count of zero still emits one row; anything above the table size
  // is capped at the table size.
  function automatic int unsigned effective_count(logic [COUNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > DVRU_MAX_NODES) return DVRU_MAX_NODES;
    return c;
  endfunction

  // Bellman-Ford relaxation of one accepted entry. An entry flagged last is
  // applied first, then the whole table is read out and the seen marks reset.
  function automatic void relax_entry(in_item_t e);
    logic [COST_OUT_W-1:0] cand;
    int unsigned           n;
    logic                  self_row;
    out_item_t             row;
    cand = COST_OUT_W'(e.link_delay) + COST_OUT_W'(e.advertised_cost);
    if (int'(e.dest_index) < DVRU_MAX_NODES) begin
      // A strict compare keeps the earlier neighbor on a tie.
      if (!route_seen[e.dest_index] || cand < route_cost[e.dest_index]) begin
        route_cost[e.dest_index] = cand;
        route_hop[e.dest_index]  = e.neighbor_id;
        route_seen[e.dest_index] = 1'b1;
      end
    end
    if (e.last_entry) begin
      n = effective_count(dest_count);
      for (int unsigned d = 0; d < n; d++) begin
        self_row        = (d == self_id);
        row.route_dest  = NODE_W'(d);
        row.path_cost   = (!self_row && route_seen[d]) ? route_cost[d] : '0;
        row.next_hop    = (!self_row && route_seen[d]) ? route_hop[d] : '0;
        row.is_self     = self_row;
        row.unreachable = !self_row && !route_seen[d];
        row.last_row    = (d + 1 == n);
        rows_due.push_back(row);
      end
      route_seen = '0;
      n_tables++;
    end
  endfunction

  function automatic void check_field(string name, logic [COST_OUT_W-1:0] want,
                                      logic [COST_OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_row(out_item_t got);
    out_item_t want;
    if (rows_due.size() == 0) begin
      $error("route row for destination %0d arrived with none outstanding", got.route_dest);
      errors++;
      return;
    end
    want = rows_due.pop_front();
    check_field("route_dest", want.route_dest, got.route_dest);
    check_field("path_cost", want.path_cost, got.path_cost);
    check_field("next_hop", want.next_hop, got.next_hop);
    check_field("is_self", want.is_self, got.is_self);
    check_field("unreachable", want.unreachable, got.unreachable);
    check_field("last_row", want.last_row, got.last_row);
    n_rows++;
  endfunction

  // Input driver. A transaction completes at an edge with valid and ready
  // both high; the entry is relaxed into the local tables right there. A new
  // entry is presented only once the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        relax_entry(in_data);
        n_entries++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (entry_backlog.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= entry_backlog.pop_front();
          tx_wait = quiet ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Ready is dropped at random, and for one long stretch on
  // request, so the block has to hold rows and back up its input side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_row(out_data);
      if (rx_hold_req != rx_hold_ack) begin
        rx_hold_ack = rx_hold_req;
        rx_wait     = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        rx_wait = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d rows outstanding.",
               cycle_count, rows_due.size());
      $display("[distance_vector_route_update_unit] ERROR");
      $finish;
    end
  end

  function automatic void push_entry(logic [NODE_W-1:0] nb, logic [COST_IN_W-1:0] delay,
                                     logic [NODE_W-1:0] dest, logic [COST_IN_W-1:0] adv,
                                     logic last);
    in_item_t e;
    e.neighbor_id     = nb;
    e.link_delay      = delay;
    e.dest_index      = dest;
    e.advertised_cost = adv;
    e.last_entry      = last;
    entry_backlog.push_back(e);
    n_pushed++;
  endfunction

  function automatic logic [COST_IN_W-1:0] pick_cost();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return COST_IN_W'($urandom_range(15));
      default: return COST_IN_W'($urandom);
    endcase
  endfunction

  // Queues one batch of entries. Most destinations fall inside the emitted
  // range, some beyond it; about a quarter of repeat destinations get an
  // exact tie with the best sum so far, split differently between delay and
  // advertised cost.
  function automatic void queue_route_batch(int unsigned len, bit closes);
    int unsigned       eff, sum, lo, hi;
    logic [NODE_W-1:0] dest, nb;
    logic [COST_IN_W-1:0] delay, adv;
    logic              last;
    eff = effective_count(dest_count);
    for (int unsigned k = 0; k < len; k++) begin
      dest = ($urandom_range(5) == 0) ? NODE_W'($urandom_range(DVRU_MAX_NODES - 1))
                                      : NODE_W'($urandom_range(eff - 1));
      nb   = ($urandom_range(7) == 0) ? self_id : NODE_W'($urandom);
      if (offer_seen[dest] && $urandom_range(3) == 0) begin
        sum   = offer_best[dest];
        lo    = (sum > 65535) ? sum - 65535 : 0;
        hi    = (sum < 65535) ? sum : 65535;
        delay = COST_IN_W'($urandom_range(hi, lo));
        adv   = COST_IN_W'(sum - delay);
      end else begin
        delay = pick_cost();
        adv   = pick_cost();
      end
      sum = delay + adv;
      if (!offer_seen[dest] || sum < offer_best[dest]) begin
        offer_best[dest] = sum;
        offer_seen[dest] = 1'b1;
      end
      last = closes && (k + 1 == len);
      push_entry(nb, delay, dest, adv, last);
      if (last) begin
        foreach (offer_seen[i]) offer_seen[i] = 1'b0;
      end
    end
  endfunction

  // Registers only change while the block is idle: every entry taken, every
  // row delivered, and a few more cycles for an entry still being applied.
  task automatic settle();
    while (entry_backlog.size() != 0 || in_valid || rows_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SELF_INDEX: self_id    = val[NODE_W-1:0];
      CFG_NODE_COUNT: dest_count = val;
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Picks new settings with a bias toward the extremes: zero, one, the full
  // table, counts above it, and self indexes with the unused top bit set.
  task automatic random_config();
    logic [CFG_DATA_W-1:0] sv, cv;
    case ($urandom_range(3))
      0:       sv = '0;
      1:       sv = CFG_DATA_W'(DVRU_MAX_NODES - 1);
      default: sv = CFG_DATA_W'($urandom);
    endcase
    case ($urandom_range(5))
      0:       cv = '0;
      1:       cv = CFG_DATA_W'(1);
      2:       cv = CFG_DATA_W'(DVRU_MAX_NODES);
      3:       cv = CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1, DVRU_MAX_NODES + 1));
      default: cv = CFG_DATA_W'($urandom_range(DVRU_MAX_NODES - 1, 2));
    endcase
    if ($urandom_range(1) == 0) begin
      cfg_write(CFG_SELF_INDEX, sv);
      cfg_write(CFG_NODE_COUNT, cv);
    end else begin
      cfg_write(CFG_NODE_COUNT, cv);
      cfg_write(CFG_SELF_INDEX, sv);
    end
  endtask

  task automatic stray_cfg_write();
    cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_NODE_COUNT + 1)),
              CFG_DATA_W'($urandom));
  endtask

  initial begin
    int unsigned first_random, batch, len, r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default settings: cheaper route replaces a worse one, an exact tie keeps
    // the first neighbor, an entry for the own router, a neighbor equal to
    // self, and the largest possible sum.
    push_entry(4'd15, '1, 4'd15, '1, 1'b0);
    push_entry(4'd3, '0, 4'd15, '0, 1'b0);
    push_entry(4'd7, '0, 4'd15, '0, 1'b0);
    push_entry(4'd5, 16'd10, 4'd0, 16'd10, 1'b0);
    push_entry(4'd0, 16'd1, 4'd1, 16'd2, 1'b0);
    push_entry(4'd9, '1, 4'd2, '1, 1'b0);
    push_entry(4'd10, '1, 4'd2, '0, 1'b0);
    push_entry(4'd11, 16'h8000, 4'd14, 16'h7fff, 1'b1);
    settle();

    // Node count zero emits a single row; an entry beyond it is not emitted.
    cfg_write(CFG_SELF_INDEX, 5'b10101);
    cfg_write(CFG_NODE_COUNT, '0);
    push_entry(4'd2, 16'd100, 4'd3, 16'd50, 1'b0);
    push_entry(4'd6, 16'd1, 4'd0, 16'd1, 1'b1);
    settle();

    // Count above the table size is capped; a tie after an improvement.
    cfg_write(CFG_NODE_COUNT, '1);
    push_entry(4'd1, 16'd20, 4'd4, 16'd20, 1'b0);
    push_entry(4'd2, 16'd5, 4'd4, 16'd5, 1'b0);
    push_entry(4'd12, 16'd3, 4'd4, 16'd7, 1'b0);
    push_entry(4'd5, '0, 4'd5, '0, 1'b1);
    settle();

    // One-row table that is the own router.
    cfg_write(CFG_NODE_COUNT, 5'd1);
    cfg_write(CFG_SELF_INDEX, '0);
    push_entry(4'd4, 16'd7, 4'd0, 16'd7, 1'b1);
    settle();

    // Own router on the final row.
    cfg_write(CFG_NODE_COUNT, 5'd17);
    cfg_write(CFG_SELF_INDEX, 5'd15);
    push_entry(4'd14, 16'd123, 4'd15, 16'd456, 1'b0);
    push_entry(4'd13, 16'haaaa, 4'd7, 16'h5555, 1'b1);
    settle();

    // Self index outside the emitted range, plus a write to an unused index.
    cfg_write(CFG_NODE_COUNT, 5'd4);
    cfg_write(CFG_SELF_INDEX, 5'd9);
    stray_cfg_write();
    push_entry(4'd9, 16'd1, 4'd3, 16'd1, 1'b0);
    push_entry(4'd3, '1, 4'd1, 16'd1, 1'b1);

    // Node count changed while a table is half built; it applies at readout.
    push_entry(4'd1, 16'd2, 4'd2, 16'd2, 1'b0);
    settle();
    cfg_write(CFG_NODE_COUNT, 5'd3);
    push_entry(4'd2, '0, 4'd2, 16'd5, 1'b1);
    settle();
    cfg_write(CFG_SELF_INDEX, '0);
    cfg_write(CFG_NODE_COUNT, CFG_DATA_W'(DVRU_MAX_NODES));

    // Random batches under changing settings, with a few special phases.
    first_random = n_pushed;
    batch = 0;
    while (n_pushed - first_random < RANDOM_ITEMS) begin
      batch++;
      while (entry_backlog.size() > 8) @(negedge clk);
      quiet = ($urandom_range(7) == 0);
      if (batch == 8) begin
        // Receiver goes quiet for a long stretch while full tables keep
        // coming, so the output register, the queue and the input all back up.
        settle();
        cfg_write(CFG_NODE_COUNT, CFG_DATA_W'(DVRU_MAX_NODES));
        rx_hold_req = !rx_hold_req;
        repeat (3) queue_route_batch(4, 1'b1);
        settle();
      end else if ($urandom_range(9) == 0) begin
        // Partial table, register change while idle, then the rest of it.
        queue_route_batch($urandom_range(4, 1), 1'b0);
        settle();
        random_config();
        queue_route_batch($urandom_range(4, 1), 1'b1);
      end else begin
        if ($urandom_range(2) == 0) begin
          settle();
          random_config();
        end
        if ($urandom_range(11) == 0) begin
          settle();
          stray_cfg_write();
        end
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(6, 1);
        else if (r < 95) len = $urandom_range(16, 7);
        else len = $urandom_range(24, 17);
        // Now and then a batch ends without its last entry and runs on into
        // the next one.
        queue_route_batch(len, $urandom_range(9) != 0);
      end
    end

    while (entry_backlog.size() != 0 || in_valid) @(negedge clk);
    while (rows_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d entries, %0d tables, %0d rows, %0d register writes.",
             n_entries, n_tables, n_rows, n_cfg);
    if (errors == 0) begin
      $display("[distance_vector_route_update_unit] OK");
    end else begin
      $display("%0d mismatches.", errors);
      $display("[distance_vector_route_update_unit] ERROR");
    end
    $finish;
  end

endmodule
